/* sv/wfg_pkg.sv */
// shared types, constants and helpers for the wait-for graph cycle detector
// no dependencies
`default_nettype none
package wfg_pkg;

    localparam int NODE_W       = 4;
    localparam int MASK_W       = 16;
    localparam int CNT_W        = 5;
    localparam int MAX_PROCS_DEF = 16;
    localparam int ROW_CAP      = 16;
    localparam logic [CNT_W-1:0] PCOUNT_RST = 5'd16;

    localparam logic CFG_PCOUNT = 1'b0;
    localparam logic CFG_PREV   = 1'b1;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_DETECT = 1'b1;

    typedef struct packed {
        logic do_write;
        logic init;
        logic push_root;
        logic step;
        logic emit_path;
        logic emit_close;
        logic emit_none;
    } t_cmd;

    typedef struct packed {
        logic has_unvisited;
        logic has_nbr;
        logic nbr_new;
        logic nbr_on_stack;
        logic depth_one;
        logic emit_end;
    } t_status;

    function automatic logic [NODE_W-1:0] lowest_set(input logic [MASK_W-1:0] v);
        logic [NODE_W-1:0] idx;
        idx = '0;
        for (int i = MASK_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = NODE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage
`default_nettype wire

/* sv/wfg_ctrl.sv */
// controller state machine for the wait-for graph cycle detector
// depends on wfg_pkg (command and status structs)
`default_nettype none
module wfg_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_mode,
    input  wfg_pkg::t_status i_status,
    output wfg_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROOT  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_CLOSE = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == wfg_pkg::MODE_WRITE) begin
                        o_cmd.do_write = 1'b1;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state    = S_ROOT;
                    end
                end
            end
            S_ROOT: begin
                if (i_status.has_unvisited) begin
                    o_cmd.push_root = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (!i_status.has_nbr) begin
                    if (i_status.depth_one) begin
                        n_state = S_ROOT;
                    end
                end else if (!i_status.nbr_new && i_status.nbr_on_stack) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit_path = 1'b1;
                if (i_status.emit_end) begin
                    n_state = S_CLOSE;
                end
            end
            S_CLOSE: begin
                o_cmd.emit_close = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

/* sv/wfg_dp.sv */
// datapath: wait rows, search marks, path stack, cursors and result register
// depends on wfg_pkg; driven by wfg_ctrl commands
`default_nettype none
module wfg_dp #(
    parameter int ROW_LIMIT = 16
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire                                i_cfg_index,
    input  wire  [wfg_pkg::CNT_W-1:0]          i_cfg_data,
    input  wire  [wfg_pkg::NODE_W-1:0]         i_process,
    input  wire  [wfg_pkg::MASK_W-1:0]         i_wait_mask,
    input  wfg_pkg::t_cmd                      i_cmd,
    output wfg_pkg::t_status                   o_status,
    output logic                               o_valid,
    output logic                               o_found,
    output logic [wfg_pkg::NODE_W-1:0]         o_node,
    output logic                               o_is_closing,
    output logic [wfg_pkg::MASK_W-1:0]         o_stored_row,
    output logic [wfg_pkg::MASK_W-1:0]         o_rejected_bits,
    output logic                               o_bad_index,
    output logic                               o_last
);
    localparam int IDX_W = $clog2(ROW_LIMIT);
    localparam int DEP_W = $clog2(ROW_LIMIT + 1);
    localparam logic [wfg_pkg::CNT_W-1:0] LIMIT_C = wfg_pkg::CNT_W'(ROW_LIMIT);

    logic [wfg_pkg::CNT_W-1:0]  r_pcount;
    logic                       r_prev;
    logic [wfg_pkg::MASK_W-1:0] r_rows [ROW_LIMIT];
    logic [wfg_pkg::MASK_W-1:0] r_visited;
    logic [wfg_pkg::MASK_W-1:0] r_onstk;
    logic [wfg_pkg::NODE_W-1:0] r_stack [ROW_LIMIT];
    logic [wfg_pkg::CNT_W-1:0]  r_cur [ROW_LIMIT];
    logic [DEP_W-1:0]           r_depth;
    logic [DEP_W-1:0]           r_emit_idx;
    logic [wfg_pkg::NODE_W-1:0] r_close;

    logic                       r_valid;
    logic                       r_found;
    logic [wfg_pkg::NODE_W-1:0] r_node;
    logic                       r_is_closing;
    logic [wfg_pkg::MASK_W-1:0] r_stored_row;
    logic [wfg_pkg::MASK_W-1:0] r_rejected_bits;
    logic                       r_bad_index;
    logic                       r_last;

    logic [wfg_pkg::CNT_W-1:0]  eff_n;
    logic [wfg_pkg::MASK_W-1:0] cmask;
    logic [wfg_pkg::MASK_W-1:0] low_mask;
    logic [wfg_pkg::MASK_W-1:0] wr_mask;
    logic [wfg_pkg::MASK_W-1:0] unvisited;
    logic [wfg_pkg::NODE_W-1:0] root_sel;
    logic [DEP_W-1:0]           lvl;
    logic [wfg_pkg::NODE_W-1:0] top;
    logic [wfg_pkg::CNT_W-1:0]  cur;
    logic [wfg_pkg::MASK_W-1:0] cur_mask;
    logic [wfg_pkg::MASK_W-1:0] cand;
    logic [wfg_pkg::NODE_W-1:0] nbr;
    logic                       bad;

    always_comb begin
        if (r_pcount == '0) begin
            eff_n = wfg_pkg::CNT_W'(1);
        end else if (r_pcount > LIMIT_C) begin
            eff_n = LIMIT_C;
        end else begin
            eff_n = r_pcount;
        end
        for (int i = 0; i < wfg_pkg::MASK_W; i++) begin
            cmask[i]    = (wfg_pkg::CNT_W'(i) < eff_n);
            low_mask[i] = (wfg_pkg::NODE_W'(i) <= i_process);
        end
    end

    assign bad     = ({1'b0, i_process} >= eff_n);
    assign wr_mask = i_wait_mask & cmask;

    assign unvisited = ~r_visited & cmask;
    assign root_sel  = wfg_pkg::lowest_set(unvisited);

    assign lvl = r_depth - DEP_W'(1);
    assign top = r_stack[lvl[IDX_W-1:0]];
    assign cur = r_cur[lvl[IDX_W-1:0]];

    always_comb begin
        for (int i = 0; i < wfg_pkg::MASK_W; i++) begin
            cur_mask[i] = (wfg_pkg::CNT_W'(i) >= cur);
        end
    end

    assign cand = r_rows[top[IDX_W-1:0]] & cmask & cur_mask;
    assign nbr  = wfg_pkg::lowest_set(cand);

    assign o_status.has_unvisited = |unvisited;
    assign o_status.has_nbr       = |cand;
    assign o_status.nbr_new       = !r_visited[nbr];
    assign o_status.nbr_on_stack  = r_onstk[nbr];
    assign o_status.depth_one     = (r_depth == DEP_W'(1));
    assign o_status.emit_end      = (r_emit_idx == lvl);

    // configuration and wait rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= wfg_pkg::PCOUNT_RST;
            r_prev   <= 1'b0;
            for (int i = 0; i < ROW_LIMIT; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    wfg_pkg::CFG_PCOUNT: r_pcount <= i_cfg_data;
                    wfg_pkg::CFG_PREV:   r_prev   <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.do_write && !bad) begin
                r_rows[i_process[IDX_W-1:0]] <= r_prev ? (wr_mask & ~low_mask) : wr_mask;
            end
        end
    end

    // search marks and depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
            r_onstk   <= '0;
            r_depth   <= '0;
        end else if (i_cmd.init) begin
            r_visited <= '0;
            r_onstk   <= '0;
            r_depth   <= '0;
        end else if (i_cmd.push_root) begin
            r_visited[root_sel] <= 1'b1;
            r_onstk[root_sel]   <= 1'b1;
            r_depth             <= r_depth + DEP_W'(1);
        end else if (i_cmd.step) begin
            if (!(|cand)) begin
                r_onstk[top] <= 1'b0;
                r_depth      <= lvl;
            end else if (!r_visited[nbr]) begin
                r_visited[nbr] <= 1'b1;
                r_onstk[nbr]   <= 1'b1;
                r_depth        <= r_depth + DEP_W'(1);
            end
        end
    end

    // path stack, cursors, emit pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_root) begin
            r_stack[r_depth[IDX_W-1:0]] <= root_sel;
            r_cur[r_depth[IDX_W-1:0]]   <= '0;
        end else if (i_cmd.step && (|cand)) begin
            r_cur[lvl[IDX_W-1:0]] <= {1'b0, nbr} + wfg_pkg::CNT_W'(1);
            if (!r_visited[nbr]) begin
                r_stack[r_depth[IDX_W-1:0]] <= nbr;
                r_cur[r_depth[IDX_W-1:0]]   <= '0;
            end
        end
        if (i_cmd.step) begin
            r_close    <= nbr;
            r_emit_idx <= '0;
        end else if (i_cmd.emit_path) begin
            r_emit_idx <= r_emit_idx + DEP_W'(1);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.do_write | i_cmd.emit_path | i_cmd.emit_close | i_cmd.emit_none;
        end
    end

    always_ff @(posedge i_clk) begin
        r_found      <= i_cmd.emit_path | i_cmd.emit_close;
        r_is_closing <= i_cmd.emit_close;
        r_last       <= !i_cmd.emit_path;
        r_bad_index  <= i_cmd.do_write & bad;
        if (i_cmd.do_write && !bad) begin
            r_stored_row    <= r_prev ? (wr_mask & ~low_mask) : wr_mask;
            r_rejected_bits <= r_prev ? (wr_mask & low_mask) : '0;
        end else begin
            r_stored_row    <= '0;
            r_rejected_bits <= '0;
        end
        if (i_cmd.emit_path) begin
            r_node <= r_stack[r_emit_idx[IDX_W-1:0]];
        end else if (i_cmd.emit_close) begin
            r_node <= r_close;
        end else begin
            r_node <= '0;
        end
    end

    assign o_valid         = r_valid;
    assign o_found         = r_found;
    assign o_node          = r_node;
    assign o_is_closing    = r_is_closing;
    assign o_stored_row    = r_stored_row;
    assign o_rejected_bits = r_rejected_bits;
    assign o_bad_index     = r_bad_index;
    assign o_last          = r_last;

endmodule
`default_nettype wire

/* sv/wait_for_graph_cycle_detect.sv */
// top level of the wait-for graph cycle detector
// depends on wfg_pkg, wfg_ctrl, wfg_dp
//
// channel   direction  handshake             payload
// request   in         i_start & !o_busy     i_mode, i_process, i_wait_mask
// result    out        o_valid (one cycle)   o_found, o_node, o_is_closing,
//                                            o_stored_row, o_rejected_bits,
//                                            o_bad_index, o_last
// config    in         i_cfg_we              i_cfg_index, i_cfg_data
//
// a write request is done from the idle state; its result shows the next cycle and o_busy stays low
// a detect request walks the graph one edge or one pop per cycle in the scan state
// results of a detection come on consecutive cycles, the last one with o_last
// synchronous active-low reset clears the rows, marks and state; no clearing pass
// the receiver cannot stall; results are never held
`default_nettype none
module wait_for_graph_cycle_detect #(
    parameter int MAX_PROCS = wfg_pkg::MAX_PROCS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_start,
    output logic                         o_busy,
    input  wire                          i_mode,
    input  wire  [wfg_pkg::NODE_W-1:0]   i_process,
    input  wire  [wfg_pkg::MASK_W-1:0]   i_wait_mask,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire  [wfg_pkg::CNT_W-1:0]    i_cfg_data,
    output logic                         o_valid,
    output logic                         o_found,
    output logic [wfg_pkg::NODE_W-1:0]   o_node,
    output logic                         o_is_closing,
    output logic [wfg_pkg::MASK_W-1:0]   o_stored_row,
    output logic [wfg_pkg::MASK_W-1:0]   o_rejected_bits,
    output logic                         o_bad_index,
    output logic                         o_last
);
    localparam int ROW_LIMIT = (MAX_PROCS < wfg_pkg::ROW_CAP) ? MAX_PROCS : wfg_pkg::ROW_CAP;

    wfg_pkg::t_cmd    cmd;
    wfg_pkg::t_status status;

    wfg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    wfg_dp #(
        .ROW_LIMIT (ROW_LIMIT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_process       (i_process),
        .i_wait_mask     (i_wait_mask),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_node          (o_node),
        .o_is_closing    (o_is_closing),
        .o_stored_row    (o_stored_row),
        .o_rejected_bits (o_rejected_bits),
        .o_bad_index     (o_bad_index),
        .o_last          (o_last)
    );

    a_close_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_closing |-> o_last && o_found)
        else $error("closing result not marked last and found");

    a_write_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && (i_mode == wfg_pkg::MODE_WRITE) |=> o_valid && o_last)
        else $error("write request gave no result next cycle");

    a_path_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |=> o_valid)
        else $error("path result not followed by another result");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy)
        else $error("final result shown while still busy");

endmodule
`default_nettype wire

/* tb/tb_wait_for_graph_cycle_detect.sv */
`timescale 1ns / 100ps
// self-checking bench for wait_for_graph_cycle_detect: row writes and depth-first
// cycle searches checked against an in-bench copy of the wait-for graph
// depends on wfg_pkg and wait_for_graph_cycle_detect
module tb_wait_for_graph_cycle_detect;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_ITEMS = 350;

    typedef enum logic {REQ_ITEM, REQ_CFG} t_req_kind;

    typedef struct packed {
        t_req_kind                    kind;
        logic                         mode;
        logic [wfg_pkg::NODE_W-1:0]   proc_id;
        logic [wfg_pkg::MASK_W-1:0]   wait_mask;
        logic                         cfg_index;
        logic [wfg_pkg::CNT_W-1:0]    cfg_data;
    } t_request;

    typedef struct packed {
        logic                         found;
        logic [wfg_pkg::NODE_W-1:0]   node;
        logic                         is_closing;
        logic [wfg_pkg::MASK_W-1:0]   stored_row;
        logic [wfg_pkg::MASK_W-1:0]   rejected_bits;
        logic                         bad_index;
        logic                         last;
    } t_report;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_start = 1'b0;
    logic                         i_mode = wfg_pkg::MODE_WRITE;
    logic [wfg_pkg::NODE_W-1:0]   i_process = '0;
    logic [wfg_pkg::MASK_W-1:0]   i_wait_mask = '0;
    logic                         i_cfg_we = 1'b0;
    logic                         i_cfg_index = wfg_pkg::CFG_PCOUNT;
    logic [wfg_pkg::CNT_W-1:0]    i_cfg_data = '0;
    logic                         o_busy;
    logic                         o_valid;
    logic                         o_found;
    logic [wfg_pkg::NODE_W-1:0]   o_node;
    logic                         o_is_closing;
    logic [wfg_pkg::MASK_W-1:0]   o_stored_row;
    logic [wfg_pkg::MASK_W-1:0]   o_rejected_bits;
    logic                         o_bad_index;
    logic                         o_last;

    t_request                     request_fifo [$];
    t_report                      due_reports [$];
    t_request                     shown;
    logic [wfg_pkg::MASK_W-1:0]   shadow_rows [wfg_pkg::ROW_CAP];
    logic [wfg_pkg::CNT_W-1:0]    shadow_count = wfg_pkg::PCOUNT_RST;
    logic                         shadow_prevent = 1'b0;
    int                           gap_left = 0;
    int                           burst_left = 0;
    int                           items_queued = 0;
    int                           requests_done = 0;
    int                           error_count = 0;
    int                           idle_cycles = 0;

    wait_for_graph_cycle_detect dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_mode          (i_mode),
        .i_process       (i_process),
        .i_wait_mask     (i_wait_mask),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_node          (o_node),
        .o_is_closing    (o_is_closing),
        .o_stored_row    (o_stored_row),
        .o_rejected_bits (o_rejected_bits),
        .o_bad_index     (o_bad_index),
        .o_last          (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        for (int i = 0; i < wfg_pkg::ROW_CAP; i++) begin
            shadow_rows[i] = '0;
        end
    end

    function automatic void expect_report(input t_report rep);
        due_reports.insert(due_reports.size(), rep);
    endfunction

    function automatic void queue_request(input t_request r);
        request_fifo.insert(request_fifo.size(), r);
    endfunction

    // row write or depth-first search on the shadow graph
    function automatic void walk_wait_graph(input t_request r);
        int                           n;
        int                           depth;
        int                           j;
        int                           cursor [wfg_pkg::ROW_CAP];
        logic [wfg_pkg::NODE_W-1:0]   path [wfg_pkg::ROW_CAP];
        logic [wfg_pkg::MASK_W-1:0]   cmask;
        logic [wfg_pkg::MASK_W-1:0]   row;
        logic [wfg_pkg::MASK_W-1:0]   low;
        logic [wfg_pkg::MASK_W-1:0]   seen;
        logic [wfg_pkg::MASK_W-1:0]   on_path;
        logic                         closed;
        t_report                      rep;
        if (shadow_count == 0) begin
            n = 1;
        end else if (shadow_count > wfg_pkg::ROW_CAP) begin
            n = wfg_pkg::ROW_CAP;
        end else begin
            n = int'(shadow_count);
        end
        cmask = wfg_pkg::MASK_W'((17'd1 << n) - 17'd1);
        rep = '0;
        if (r.mode == wfg_pkg::MODE_WRITE) begin
            rep.last = 1'b1;
            if (int'(r.proc_id) >= n) begin
                rep.bad_index = 1'b1;
            end else begin
                row = r.wait_mask & cmask;
                if (shadow_prevent) begin
                    low = wfg_pkg::MASK_W'((17'd1 << (int'(r.proc_id) + 1)) - 17'd1);
                    rep.rejected_bits = row & low;
                    row = row & ~low;
                end
                shadow_rows[r.proc_id] = row;
                rep.stored_row = row;
            end
            expect_report(rep);
            return;
        end
        seen = '0;
        on_path = '0;
        depth = 0;
        closed = 1'b0;
        for (int root = 0; root < n && !closed; root++) begin
            if (!seen[root]) begin
                seen[root] = 1'b1;
                on_path[root] = 1'b1;
                path[0] = wfg_pkg::NODE_W'(root);
                cursor[0] = 0;
                depth = 1;
                while (depth > 0 && !closed) begin
                    row = shadow_rows[path[depth-1]] & cmask;
                    j = cursor[depth-1];
                    while (j < n && !row[j]) begin
                        j++;
                    end
                    if (j >= n) begin
                        on_path[path[depth-1]] = 1'b0;
                        depth--;
                    end else begin
                        cursor[depth-1] = j + 1;
                        if (!seen[j]) begin
                            seen[j] = 1'b1;
                            on_path[j] = 1'b1;
                            path[depth] = wfg_pkg::NODE_W'(j);
                            cursor[depth] = 0;
                            depth++;
                        end else if (on_path[j]) begin
                            for (int d = 0; d < depth; d++) begin
                                rep = '0;
                                rep.found = 1'b1;
                                rep.node = path[d];
                                expect_report(rep);
                            end
                            rep = '0;
                            rep.found = 1'b1;
                            rep.node = wfg_pkg::NODE_W'(j);
                            rep.is_closing = 1'b1;
                            rep.last = 1'b1;
                            expect_report(rep);
                            closed = 1'b1;
                        end
                    end
                end
            end
        end
        if (!closed) begin
            rep = '0;
            rep.last = 1'b1;
            expect_report(rep);
        end
    endfunction

    function automatic int draw_gap();
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(8, 30);
        end
        return $urandom_range(0, 14);
    endfunction

    function automatic logic [wfg_pkg::MASK_W-1:0] draw_mask(
        input logic [wfg_pkg::NODE_W-1:0] row
    );
        logic [wfg_pkg::MASK_W-1:0] m;
        m = wfg_pkg::MASK_W'($urandom);
        case ($urandom_range(0, 6))
            0: m = m & wfg_pkg::MASK_W'($urandom) & wfg_pkg::MASK_W'($urandom);
            1: m = m & wfg_pkg::MASK_W'($urandom);
            2: m = wfg_pkg::MASK_W'(1 << $urandom_range(0, wfg_pkg::MASK_W - 1));
            3: m = '0;
            4: m = '1;
            // forward waits only, long acyclic walks
            5: m = m & wfg_pkg::MASK_W'($urandom) & ~wfg_pkg::MASK_W'((2 << row) - 1);
            default: ;
        endcase
        return m;
    endfunction

    function automatic void add_write(input logic [wfg_pkg::NODE_W-1:0] p,
                                      input logic [wfg_pkg::MASK_W-1:0] m);
        t_request r;
        r = '0;
        r.kind = REQ_ITEM;
        r.mode = wfg_pkg::MODE_WRITE;
        r.proc_id = p;
        r.wait_mask = m;
        queue_request(r);
        items_queued++;
    endfunction

    function automatic void add_detect();
        t_request r;
        r = '0;
        r.kind = REQ_ITEM;
        r.mode = wfg_pkg::MODE_DETECT;
        r.proc_id = wfg_pkg::NODE_W'($urandom);
        r.wait_mask = wfg_pkg::MASK_W'($urandom);
        queue_request(r);
        items_queued++;
    endfunction

    function automatic void add_cfg(input logic idx, input logic [wfg_pkg::CNT_W-1:0] data);
        t_request r;
        r = '0;
        r.kind = REQ_CFG;
        r.cfg_index = idx;
        r.cfg_data = data;
        queue_request(r);
    endfunction

    task automatic check_field(input string name, input logic [wfg_pkg::MASK_W-1:0] want,
                               input logic [wfg_pkg::MASK_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        t_request head;
        logic     hold;
        logic     next_start;
        logic     next_we;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            hold = i_start && o_busy;
            if (i_start && !o_busy) begin
                walk_wait_graph(shown);
                requests_done++;
            end
            next_start = hold;
            next_we = 1'b0;
            if (!hold) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_fifo.size() != 0) begin
                    head = request_fifo[0];
                    if (head.kind == REQ_ITEM) begin
                        head = request_fifo.pop_front();
                        shown = head;
                        next_start = 1'b1;
                        i_mode <= head.mode;
                        i_process <= head.proc_id;
                        i_wait_mask <= head.wait_mask;
                        gap_left = draw_gap();
                    end else if (!i_start && !o_busy && !o_valid && due_reports.size() == 0) begin
                        head = request_fifo.pop_front();
                        next_we = 1'b1;
                        i_cfg_index <= head.cfg_index;
                        i_cfg_data <= head.cfg_data;
                        if (head.cfg_index == wfg_pkg::CFG_PCOUNT) begin
                            shadow_count = head.cfg_data;
                        end else begin
                            shadow_prevent = head.cfg_data[0];
                        end
                        requests_done++;
                    end
                end
            end
            i_start <= next_start;
            i_cfg_we <= next_we;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid) begin
            if (due_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual node %0h last %0b",
                         $time, o_node, o_last);
                error_count++;
            end else begin
                want = due_reports.pop_front();
                check_field("found", want.found, o_found);
                check_field("node", want.node, o_node);
                check_field("is_closing", want.is_closing, o_is_closing);
                check_field("stored_row", want.stored_row, o_stored_row);
                check_field("rejected_bits", want.rejected_bits, o_rejected_bits);
                check_field("bad_index", want.bad_index, o_bad_index);
                check_field("last", want.last, o_last);
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                           total;
        int                           cnt;
        int                           eff;
        logic [wfg_pkg::NODE_W-1:0]   row;

        // empty graph, then a ring through all sixteen processes
        add_detect();
        for (int i = 0; i < 15; i++) begin
            add_write(wfg_pkg::NODE_W'(i), wfg_pkg::MASK_W'(1 << (i + 1)));
        end
        add_write(4'd15, 16'h0001);
        add_detect();
        // prevention drops every wait of the top row
        add_cfg(wfg_pkg::CFG_PREV, 5'd1);
        add_write(4'd15, 16'hffff);
        // count lowered: bad index, masked row, no cycle among the first four
        add_cfg(wfg_pkg::CFG_PCOUNT, 5'd4);
        add_write(4'd5, 16'hffff);
        add_write(4'd1, 16'hffff);
        add_detect();
        // count of zero acts as one, self wait
        add_cfg(wfg_pkg::CFG_PCOUNT, 5'd0);
        add_cfg(wfg_pkg::CFG_PREV, 5'd0);
        add_write(4'd0, 16'hffff);
        add_detect();
        // count above the limit
        add_cfg(wfg_pkg::CFG_PCOUNT, 5'd31);
        add_detect();
        eff = wfg_pkg::ROW_CAP;

        while (items_queued < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 6))
                    0: cnt = 0;
                    1: cnt = 1;
                    2: cnt = 16;
                    3: cnt = 31;
                    default: cnt = $urandom_range(2, 16);
                endcase
                add_cfg(wfg_pkg::CFG_PCOUNT, wfg_pkg::CNT_W'(cnt));
                eff = (cnt == 0) ? 1 : ((cnt > wfg_pkg::ROW_CAP) ? wfg_pkg::ROW_CAP : cnt);
                add_cfg(wfg_pkg::CFG_PREV, ($urandom_range(0, 2) == 0) ? 5'd1 : 5'd0);
            end
            if ($urandom_range(0, 9) == 0) begin
                for (int i = 0; i < eff; i++) begin
                    add_write(wfg_pkg::NODE_W'(i), '0);
                end
            end
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        add_detect();
                    end else begin
                        add_write(wfg_pkg::NODE_W'($urandom), wfg_pkg::MASK_W'($urandom));
                    end
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        row = wfg_pkg::NODE_W'($urandom);
                    end else begin
                        row = wfg_pkg::NODE_W'($urandom_range(0, eff - 1));
                    end
                    add_write(row, draw_mask(row));
                end
                add_detect();
            end
        end
        total = request_fifo.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (requests_done < total) @(posedge i_clk);
        while (due_reports.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
